[hw/rtl/epd_pkg.sv]
// ----------------------------------------------------------------------------
// epd_pkg
// Shared types and constants of the encoded pointer decoder.
// ----------------------------------------------------------------------------
package epd_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OMIT  = 2'd1,
		ST_BAD   = 2'd2,
		ST_WIDTH = 2'd3
	} status_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_ADDR_WIDTH = 3'd0,
		REG_BIG_ENDIAN = 3'd1,
		REG_PC_BASE    = 3'd2,
		REG_TEXT_BASE  = 3'd3,
		REG_DATA_BASE  = 3'd4,
		REG_FUNC_BASE  = 3'd5,
		REG_BASE_MASK  = 3'd6
	} reg_index_t;

	// Value formats (low nibble of the encoding).
	localparam logic [3:0] FMT_ABSPTR = 4'h0;
	localparam logic [3:0] FMT_ULEB   = 4'h1;
	localparam logic [3:0] FMT_UDATA2 = 4'h2;
	localparam logic [3:0] FMT_UDATA4 = 4'h3;
	localparam logic [3:0] FMT_UDATA8 = 4'h4;
	localparam logic [3:0] FMT_SLEB   = 4'h9;
	localparam logic [3:0] FMT_SDATA2 = 4'hA;
	localparam logic [3:0] FMT_SDATA4 = 4'hB;
	localparam logic [3:0] FMT_SDATA8 = 4'hC;

	// Base selects (bits 6..4 of the encoding).
	localparam logic [2:0] BASE_ABS  = 3'd0;
	localparam logic [2:0] BASE_PC   = 3'd1;
	localparam logic [2:0] BASE_TEXT = 3'd2;
	localparam logic [2:0] BASE_DATA = 3'd3;
	localparam logic [2:0] BASE_FUNC = 3'd4;

	localparam logic [7:0] ENC_OMIT    = 8'hFF;
	localparam logic [3:0] LEB_MAX_LEN = 4'd10;
	localparam logic [6:0] FULL_BITS   = 7'd64;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] encoding;
	} in_item_t;

	typedef struct packed {
		logic [63:0] pointer_value;
		logic [3:0]  bytes_used;
		logic [1:0]  status;
		logic        indirect_flag;
	} out_item_t;

	// Settings the front end reads.
	typedef struct packed {
		logic [3:0] addr_width;
		logic       big_endian;
		logic [3:0] base_mask;
	} front_cfg_t;

	// Base addresses the back end reads.
	typedef struct packed {
		logic [63:0] pc_base;
		logic [63:0] text_addr;
		logic [63:0] data_addr;
		logic [63:0] func_addr;
	} base_cfg_t;

	// A finished pointer handed from the front end to the back end.
	typedef struct packed {
		logic [63:0] raw_value;
		logic [6:0]  value_bits;
		logic        sign_extend;
		logic [2:0]  base_sel;
		logic [3:0]  bytes_used;
		status_t     status;
		logic        indirect;
	} done_rec_t;

endpackage

[hw/rtl/epd_fifo.sv]
// ----------------------------------------------------------------------------
// epd_fifo
// Small synchronous queue with full and empty flags.
// ----------------------------------------------------------------------------
module epd_fifo import epd_pkg::*; #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	T              mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == FULL_COUNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[hw/rtl/epd_front.sv]
// ----------------------------------------------------------------------------
// epd_front
// Samples the encoding, checks it, and gathers stream bytes into a value.
// ----------------------------------------------------------------------------
module epd_front import epd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  in_item_t   item,
	input  front_cfg_t cfg,
	output logic       rec_push,
	output done_rec_t  rec
);

	logic        active_q;
	logic [7:0]  enc_q;
	logic [63:0] acc_q;
	logic [3:0]  cnt_q;

	logic        start;
	logic [7:0]  enc;
	logic [63:0] acc;
	logic [3:0]  cnt;
	logic [3:0]  cnt_next;
	logic [3:0]  fmt;
	logic [2:0]  sel;
	logic        width_ok;
	logic        fmt_ok;
	logic        is_leb;
	logic [3:0]  size;
	logic        early;
	status_t     early_st;
	logic [6:0]  leb_shift;
	logic [6:0]  leb_bits;
	logic [63:0] new_acc;
	logic        finish;
	logic        fail;
	status_t     fail_st;
	logic [7:0]  b;

	always_comb begin
		b        = item.data_byte;
		start    = !active_q;
		enc      = start ? item.encoding : enc_q;
		acc      = start ? '0 : acc_q;
		cnt      = start ? '0 : cnt_q;
		cnt_next = cnt + 4'd1;
		fmt      = enc[3:0];
		sel      = enc[6:4];
		width_ok = (cfg.addr_width inside {4'd1, 4'd2, 4'd4, 4'd8});
		is_leb   = (fmt == FMT_ULEB) || (fmt == FMT_SLEB);
		fmt_ok   = (fmt inside {FMT_ABSPTR, FMT_ULEB, FMT_UDATA2, FMT_UDATA4,
			FMT_UDATA8, FMT_SLEB, FMT_SDATA2, FMT_SDATA4, FMT_SDATA8});

		case (fmt)
			FMT_ABSPTR:             size = cfg.addr_width;
			FMT_UDATA2, FMT_SDATA2: size = 4'd2;
			FMT_UDATA4, FMT_SDATA4: size = 4'd4;
			FMT_UDATA8, FMT_SDATA8: size = 4'd8;
			default:                size = 4'd0;
		endcase

		// Checks made only when a new pointer begins.
		early    = 1'b0;
		early_st = ST_OK;
		if (start) begin
			if (item.encoding == ENC_OMIT) begin
				early    = 1'b1;
				early_st = ST_OMIT;
			end else if (sel > BASE_FUNC ||
					(sel != BASE_ABS && !cfg.base_mask[2'(sel - 3'd1)])) begin
				early    = 1'b1;
				early_st = ST_BAD;
			end else if (!fmt_ok) begin
				early    = 1'b1;
				early_st = ST_BAD;
			end else if (fmt == FMT_ABSPTR && !width_ok) begin
				early    = 1'b1;
				early_st = ST_WIDTH;
			end
		end

		leb_shift = 7'({cnt, 3'b000}) - 7'(cnt);
		leb_bits  = 7'({cnt_next, 3'b000}) - 7'(cnt_next);
		if (leb_bits > FULL_BITS) begin
			leb_bits = FULL_BITS;
		end

		rec             = '0;
		rec.base_sel    = sel;
		rec.indirect    = enc[7];
		rec.status      = ST_OK;
		rec.bytes_used  = cnt_next;
		rec.value_bits  = FULL_BITS;
		finish          = 1'b0;
		fail            = 1'b0;
		fail_st         = ST_OK;
		new_acc         = acc;

		if (is_leb) begin
			new_acc          = acc | (64'(b[6:0]) << leb_shift);
			rec.raw_value    = new_acc;
			rec.value_bits   = leb_bits;
			rec.sign_extend  = (fmt == FMT_SLEB) && (leb_bits < FULL_BITS);
			if (!b[7]) begin
				finish = 1'b1;
			end else if (cnt_next >= LEB_MAX_LEN) begin
				fail    = 1'b1;
				fail_st = ST_BAD;
			end
		end else if (fmt == FMT_ABSPTR && !width_ok) begin
			// Address width became invalid during this pointer.
			fail    = 1'b1;
			fail_st = ST_WIDTH;
		end else begin
			if (cfg.big_endian) begin
				new_acc = {acc[55:0], b};
			end else begin
				new_acc = acc | (64'(b) << {cnt[2:0], 3'b000});
			end
			rec.raw_value   = new_acc;
			rec.value_bits  = (size >= 4'd8) ? FULL_BITS : 7'({size, 3'b000});
			rec.sign_extend = fmt[3] && (size < 4'd8);
			finish          = (cnt_next >= size);
		end

		if (early) begin
			rec            = '0;
			rec.status     = early_st;
		end else if (fail) begin
			rec            = '0;
			rec.status     = fail_st;
			rec.bytes_used = cnt_next;
		end

		rec_push = accept && (early || fail || finish);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			enc_q    <= '0;
			acc_q    <= '0;
			cnt_q    <= '0;
		end else if (accept && !early) begin
			enc_q <= enc;
			if (fail || finish) begin
				active_q <= 1'b0;
				acc_q    <= '0;
				cnt_q    <= '0;
			end else begin
				active_q <= 1'b1;
				acc_q    <= new_acc;
				cnt_q    <= cnt_next;
			end
		end
	end

endmodule

[hw/rtl/epd_back.sv]
// ----------------------------------------------------------------------------
// epd_back
// Trims and sign-extends a finished value and adds the selected base.
// ----------------------------------------------------------------------------
module epd_back import epd_pkg::*; (
	input  logic      rec_valid,
	input  done_rec_t rec,
	input  base_cfg_t bases,
	input  logic      out_full,
	output logic      rec_pop,
	output logic      out_push,
	output out_item_t result
);

	logic [63:0] keep_mask;
	logic [5:0]  sign_pos;
	logic [63:0] value;
	logic [63:0] base;

	always_comb begin
		rec_pop  = rec_valid && !out_full;
		out_push = rec_pop;

		keep_mask = (rec.value_bits >= FULL_BITS) ? '1 :
			((64'd1 << rec.value_bits) - 64'd1);
		sign_pos  = 6'(rec.value_bits - 7'd1);
		value     = rec.raw_value & keep_mask;
		if (rec.sign_extend && rec.raw_value[sign_pos]) begin
			value = value | ~keep_mask;
		end

		case (rec.base_sel)
			BASE_PC:   base = bases.pc_base;
			BASE_TEXT: base = bases.text_addr;
			BASE_DATA: base = bases.data_addr;
			BASE_FUNC: base = bases.func_addr;
			default:   base = '0;
		endcase

		result.bytes_used = rec.bytes_used;
		result.status     = rec.status;
		if (rec.status == ST_OK) begin
			result.pointer_value = value + base;
			result.indirect_flag = rec.indirect;
		end else begin
			result.pointer_value = '0;
			result.indirect_flag = 1'b0;
		end
	end

endmodule

[hw/rtl/dwarf_encoded_pointer_decoder.sv]
// ----------------------------------------------------------------------------
// dwarf_encoded_pointer_decoder
// Decodes exception-table style encoded pointers from a byte stream.
// ----------------------------------------------------------------------------
// Usage. Stream bytes enter through a queue-like port: a transaction happens
// on a clock edge with push high and full low, carrying one data byte and the
// encoding byte. The encoding is sampled only on the first byte of a pointer.
// Results leave through a second queue-like port: while empty is low the
// oldest result is on the result port, and pop takes it.
// Settings are written through the cfg channel (cfg_ready is always high);
// the user must write them only while no pointer is in flight, which the
// block itself does not enforce. Throughput is one byte per cycle while full
// is low. The edge that takes a pointer's last byte writes the front end's
// completion record into the middle queue; a later edge, once the output
// queue has room, has the back end (which trims the value and adds the base
// in one 64-bit add) write the result into the output queue. Encodings that
// are rejected up front produce a result; the byte is taken but not used.
// When the consumer stops popping, the output queue and then the middle
// queue fill, and full rises; no transaction is lost.
// Reset clears all queues, the gathering state and the settings (address
// width 8, little endian, all bases zero, no base available).
// ----------------------------------------------------------------------------
module dwarf_encoded_pointer_decoder import epd_pkg::*; #(
	parameter int MID_DEPTH = 2,
	parameter int OUT_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  in_item_t    item,
	output logic        full,
	input  logic        pop,
	output out_item_t   result,
	output logic        empty,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	front_cfg_t front_cfg_q;
	base_cfg_t  bases_q;

	logic      accept;
	logic      rec_push;
	done_rec_t rec_in;
	done_rec_t rec_head;
	logic      mid_empty;
	logic      rec_pop;
	logic      out_push;
	logic      out_full;
	out_item_t back_result;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	// Settings registers; indexes outside the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_cfg_q.addr_width <= 4'd8;
			front_cfg_q.big_endian <= 1'b0;
			front_cfg_q.base_mask  <= '0;
			bases_q                <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ADDR_WIDTH: front_cfg_q.addr_width <= cfg_data[3:0];
				REG_BIG_ENDIAN: front_cfg_q.big_endian <= cfg_data[0];
				REG_PC_BASE:    bases_q.pc_base        <= cfg_data;
				REG_TEXT_BASE:  bases_q.text_addr      <= cfg_data;
				REG_DATA_BASE:  bases_q.data_addr      <= cfg_data;
				REG_FUNC_BASE:  bases_q.func_addr      <= cfg_data;
				REG_BASE_MASK:  front_cfg_q.base_mask  <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	epd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg      (front_cfg_q),
		.rec_push (rec_push),
		.rec      (rec_in)
	);

	// Completion records between front and back end; its full flag is the
	// input side's full.
	epd_fifo #(
		.T     (done_rec_t),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec_in),
		.full   (full),
		.pop    (rec_pop),
		.rdata  (rec_head),
		.empty  (mid_empty)
	);

	epd_back u_back (
		.rec_valid (!mid_empty),
		.rec       (rec_head),
		.bases     (bases_q),
		.out_full  (out_full),
		.rec_pop   (rec_pop),
		.out_push  (out_push),
		.result    (back_result)
	);

	epd_fifo #(
		.T     (out_item_t),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (back_result),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
